// ===== rtl/sha_pkg.sv =====
// Shared types, constants and helper functions for the SHA-256 hash engine.
// Used by sha_sched, sha_round, sha_ctrl and sha256_hash_engine; depends on nothing.
package sha_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } sha_state_t;

    // Control group from the sequencer to the datapath modules.
    typedef struct packed {
        logic       byte_we;
        logic       word_done;
        logic [7:0] byte_val;
        logic       load;
        logic       round_en;
        logic [5:0] round_idx;
        logic       chain_add;
        logic       chain_init;
        logic [2:0] out_idx;
    } sha_ctrl_t;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    localparam logic [31:0] INIT_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RK [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Rotate right by a constant amount.
    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Message schedule sigma functions.
    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Round sigma functions.
    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ===== rtl/sha_sched.sv =====
// Byte-to-word assembly and the sixteen-word message schedule shift line.
// Depends on sha_pkg for the control group and the sigma functions.
module sha_sched
    import sha_pkg::*;
(
    input  logic        clk,
    input  sha_ctrl_t   ctrl,
    output logic [31:0] w
);

    logic [23:0] acc_reg;
    logic [23:0] acc_next;
    logic [31:0] win_reg [0:15];
    logic [31:0] win_next [0:15];
    logic [31:0] sched;

    // New schedule word from the taps of the window.
    assign sched = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    assign w     = (ctrl.round_idx < 6'd16) ? win_reg[0] : sched;

    // Next value of the byte accumulator and the window.
    always_comb
    begin
        acc_next = acc_reg;
        for (int i = 0; i < 16; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (ctrl.byte_we)
        begin
            acc_next = {acc_reg[15:0], ctrl.byte_val};
            if (ctrl.word_done)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = {acc_reg, ctrl.byte_val};
            end
        end
        else if (ctrl.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = w;
        end
    end

    // Payload registers; they carry no reset.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        for (int i = 0; i < 16; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

endmodule

// ===== rtl/sha_round.sv =====
// Shared SHA-256 round unit, working variables and the chaining hash.
// Depends on sha_pkg for the control group, constants and round functions.
module sha_round
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sha_ctrl_t   ctrl,
    input  logic [31:0] w,
    output logic [31:0] digest
);

    logic [31:0] work_reg [0:7];
    logic [31:0] work_next [0:7];
    logic [31:0] chain_reg [0:7];
    logic [31:0] chain_next [0:7];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] mj;

    // One compression round on the working variables.
    assign ch = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
    assign mj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]);
    assign t1 = work_reg[7] + bsig1(work_reg[4]) + ch + RK[ctrl.round_idx] + w;
    assign t2 = bsig0(work_reg[0]) + mj;

    assign digest = chain_reg[ctrl.out_idx];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            work_next[i]  = work_reg[i];
            chain_next[i] = chain_reg[i];
        end
        if (ctrl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_next[i] = chain_reg[i];
            end
        end
        else if (ctrl.round_en)
        begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
        // Fold the block result into the chain, or start a new message.
        if (ctrl.chain_add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
        end
        else if (ctrl.chain_init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = INIT_HASH[i];
            end
        end
    end

    // Working variables are payload and carry no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            work_reg[i] <= work_next[i];
        end
    end

    // The chaining hash starts from the standard initial values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_HASH[i];
            end
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

endmodule

// ===== rtl/sha_ctrl.sv =====
// Sequencer: byte intake, padding, round counting and digest output.
// Depends on sha_pkg for the state type, the control group and constants.
module sha_ctrl
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic [7:0] in_byte,
    input  logic      in_present,
    input  logic      in_end,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      out_last,
    output sha_ctrl_t ctrl
);

    sha_state_t  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic        pad_reg, pad_next;
    logic        mark_reg, mark_next;
    logic        len_ok_reg, len_ok_next;
    logic        fin_reg, fin_next;
    logic        len_phase;
    logic [7:0]  len_byte;

    // Length bytes go out most significant first from position 56.
    assign len_phase = len_ok_reg && (fill_reg >= LEN_START);
    assign len_byte  = 8'(len_reg >> {~fill_reg[2:0], 3'b000});

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        rnd_next    = rnd_reg;
        idx_next    = idx_reg;
        pad_next    = pad_reg;
        mark_next   = mark_reg;
        len_ok_next = len_ok_reg;
        fin_next    = fin_reg;

        in_ready  = 1'b0;
        out_valid = 1'b0;
        out_last  = 1'b0;

        ctrl            = '0;
        ctrl.word_done  = (fill_reg[1:0] == 2'd3);
        ctrl.round_idx  = rnd_reg;
        ctrl.out_idx    = idx_reg;

        case (state_reg)
            // Take one transaction; a byte goes straight into the block.
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_present)
                    begin
                        ctrl.byte_we  = 1'b1;
                        ctrl.byte_val = in_byte;
                        fill_next     = fill_reg + 6'd1;
                        len_next      = len_reg + 64'd8;
                    end
                    if (in_end)
                    begin
                        pad_next = 1'b1;
                    end
                    if (in_present && (fill_reg == 6'd63))
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (in_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end

            // One padding byte per cycle, paused while a full block is compressed: marker, zeros, then the length.
            ST_PAD:
            begin
                ctrl.byte_we = 1'b1;
                fill_next    = fill_reg + 6'd1;
                if (!mark_reg)
                begin
                    ctrl.byte_val = PAD_MARK;
                    mark_next     = 1'b1;
                    len_ok_next   = (fill_reg < LEN_START);
                end
                else if (len_phase)
                begin
                    ctrl.byte_val = len_byte;
                end
                else
                begin
                    ctrl.byte_val = 8'h00;
                end
                if (fill_reg == 6'd63)
                begin
                    fin_next   = mark_reg && len_phase;
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                ctrl.load  = 1'b1;
                rnd_next   = 6'd0;
                state_next = ST_ROUND;
            end

            ST_ROUND:
            begin
                ctrl.round_en = 1'b1;
                rnd_next      = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end

            // Fold the block in, then send the digest, go on padding or return to idle.
            ST_ADD:
            begin
                ctrl.chain_add = 1'b1;
                len_ok_next    = mark_reg;
                if (fin_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            // Eight digest transactions, then re-initialise.
            ST_OUT:
            begin
                out_valid = 1'b1;
                out_last  = (idx_reg == 3'd7);
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        ctrl.chain_init = 1'b1;
                        len_next        = 64'd0;
                        fill_next       = 6'd0;
                        pad_next        = 1'b0;
                        mark_next       = 1'b0;
                        len_ok_next     = 1'b0;
                        fin_next        = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= 6'd0;
            len_reg    <= 64'd0;
            rnd_reg    <= 6'd0;
            idx_reg    <= 3'd0;
            pad_reg    <= 1'b0;
            mark_reg   <= 1'b0;
            len_ok_reg <= 1'b0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
            pad_reg    <= pad_next;
            mark_reg   <= mark_next;
            len_ok_reg <= len_ok_next;
            fin_reg    <= fin_next;
        end
    end

endmodule

// ===== rtl/sha256_hash_engine.sv =====
// SHA-256 hash engine over a byte stream.
//
// Input channel (s_axis): one transaction per message byte. tdata carries the
// byte, tuser says whether the byte is part of the message, and tlast marks
// the end of the message (an end marker without a byte hashes what came so far,
// so the empty message can be hashed).
// Output channel (m_axis): eight transactions per message, digest words H0 to
// H7 in tdata, the word index in tuser, tlast on the eighth word.
// Flow: a byte that does not complete a block is taken and the engine stays
// ready for the next. The 64th byte of a block starts a compression (load,
// 64 rounds of the single round unit, chain update). At the end of a message
// the padding is fed one byte a cycle through the same path, pausing while a
// full block is compressed, with one or two compressions before the first
// digest word appears. s_axis_tready is low throughout that work.
// Stalls: while m_axis_tready is low the current digest word is held and no
// new input is taken. After the eighth word the chain returns to the initial
// hash values and the length count to zero.
// Reset: asynchronous and active low; the engine comes up idle and ready,
// with the initial hash values loaded.
// Depends on sha_pkg, sha_ctrl, sha_sched and sha_round.
module sha256_hash_engine
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);

    sha_ctrl_t   ctrl;
    logic [31:0] w;

    sha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .in_present (s_axis_tuser[0]),
        .in_end     (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_last   (m_axis_tlast),
        .ctrl       (ctrl)
    );

    sha_sched u_sched (
        .clk   (clk),
        .ctrl  (ctrl),
        .w     (w)
    );

    sha_round u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .w      (w),
        .digest (m_axis_tdata)
    );

    assign m_axis_tuser = ctrl.out_idx;

endmodule
